>>> design/sste_pkg.sv
// shared types and constants of the seven-segment text encoder
// no dependencies; compiled before every other design file
package sste_pkg;

  // field widths
  localparam int CHAR_W  = 8;
  localparam int SEG_W   = 8;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 8;

  // depth of the queue between the classifier and the output stage
  localparam int QUEUE_DEPTH = 2;

  // character codes and pattern masks
  localparam logic [CHAR_W-1:0]  CHAR_END        = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_DOT        = 8'h2E;
  localparam logic [SEG_W-1:0]   DP_MASK         = 8'h80;
  localparam logic [SEG_W-1:0]   INVERT_MASK     = 8'hFF;
  localparam logic [SEG_W-1:0]   UNMAPPED        = 8'hFF;
  localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 8'd8;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_INVERT    = 1'b0,
    CFG_MAX_CHARS = 1'b1
  } cfg_idx_e;

  // one queued result, pattern not yet inverted
  typedef struct packed {
    logic [SEG_W-1:0] pattern;
    logic             last;
  } seg_item_t;

endpackage

>>> design/sste_if.sv
// valid/ready channel interfaces: character input and segment output
// depends on sste_pkg for the field widths
interface sste_char_if;
  logic                        valid;
  logic                        ready;
  logic [sste_pkg::CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface sste_seg_if;
  logic                       valid;
  logic                       ready;
  logic [sste_pkg::SEG_W-1:0] segments;
  logic                       last;

  modport source (output valid, output segments, output last, input ready);
  modport sink   (input valid, input segments, input last, output ready);
endinterface

>>> design/sste_front.sv
// front end: accepts characters, maps them to glyphs, merges dots and
// tracks the string count; depends on sste_pkg and sste_if
module sste_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sste_char_if.sink                    char_i,
  input  logic [sste_pkg::COUNT_W-1:0] max_chars_i,
  input  logic                         full_i,
  output logic                         push_o,
  output sste_pkg::seg_item_t          push_item_o
);
  import sste_pkg::*;

  // glyph table, case-sensitive letters first, then folded to upper case
  function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [SEG_W-1:0]  g;
    begin
      u = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
      g = UNMAPPED;
      unique case (c)
        8'h30: g = 8'h3F; // 0
        8'h31: g = 8'h06;
        8'h32: g = 8'h5B;
        8'h33: g = 8'h4F;
        8'h34: g = 8'h66;
        8'h35: g = 8'h6D;
        8'h36: g = 8'h7D;
        8'h37: g = 8'h07;
        8'h38: g = 8'h7F;
        8'h39: g = 8'h6F; // 9
        8'h20: g = 8'h00; // space
        8'h2D: g = 8'h40; // minus
        8'h5F: g = 8'h08; // underscore
        8'h43: g = 8'h39; // C
        8'h63: g = 8'h58; // c
        8'h4E: g = 8'h37; // N
        8'h6E: g = 8'h54; // n
        8'h55: g = 8'h3E; // U
        8'h75: g = 8'h1C; // u
        8'h48: g = 8'h76; // H
        8'h68: g = 8'h74; // h
        8'h4F: g = 8'h3F; // O
        8'h6F: g = 8'h5C; // o
        default: begin
          unique case (u)
            8'h41: g = 8'h77; // A
            8'h42: g = 8'h7C; // B
            8'h44: g = 8'h5E; // D
            8'h45: g = 8'h79; // E
            8'h46: g = 8'h71; // F
            8'h50: g = 8'h73; // P
            8'h59: g = 8'h6E; // Y
            8'h4C: g = 8'h38; // L
            8'h54: g = 8'h78; // T
            8'h51: g = 8'h67; // Q
            8'h53: g = 8'h6D; // S
            8'h52: g = 8'h50; // R
            8'h4A: g = 8'h0E; // J
            default: g = UNMAPPED;
          endcase
        end
      endcase
      return g;
    end
  endfunction

  logic               pend_valid_q, pend_valid_d;
  logic [SEG_W-1:0]   pend_pattern_q, pend_pattern_d;
  logic               pend_dot_q, pend_dot_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               limit_q, limit_d;
  logic               accept;

  // a character is taken whenever the queue has room
  assign char_i.ready = !full_i;
  assign accept       = char_i.valid && !full_i;

  // classify the accepted character against the held pattern
  always_comb begin
    pend_valid_d        = pend_valid_q;
    pend_pattern_d      = pend_pattern_q;
    pend_dot_d          = pend_dot_q;
    count_d             = count_q;
    limit_d             = limit_q;
    push_o              = 1'b0;
    push_item_o.pattern = pend_pattern_q;
    push_item_o.last    = 1'b0;
    if (accept) begin
      priority if (char_i.character == CHAR_END) begin
        // end of string: flush the held pattern and restart
        push_o           = pend_valid_q;
        push_item_o.last = 1'b1;
        pend_valid_d     = 1'b0;
        pend_dot_d       = 1'b0;
        count_d          = '0;
        limit_d          = 1'b0;
      end else if (limit_q) begin
        // string already at its width: drop the character
        push_o = 1'b0;
      end else if (char_i.character == CHAR_DOT && pend_valid_q && !pend_dot_q) begin
        pend_pattern_d = pend_pattern_q | DP_MASK;
        pend_dot_d     = 1'b1;
      end else if (count_q >= max_chars_i) begin
        limit_d = 1'b1;
      end else begin
        // release the held pattern and hold the new glyph
        push_o         = pend_valid_q;
        pend_valid_d   = 1'b1;
        pend_pattern_d = glyph(char_i.character);
        pend_dot_d     = 1'b0;
        count_d        = count_q + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_dot_q   <= 1'b0;
      count_q      <= '0;
      limit_q      <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_dot_q   <= pend_dot_d;
      count_q      <= count_d;
      limit_q      <= limit_d;
    end
  end

  // held pattern, qualified by pend_valid_q
  always_ff @(posedge clk_i) begin
    pend_pattern_q <= pend_pattern_d;
  end

endmodule

>>> design/sste_fifo.sv
// short queue of pending results between front end and output stage
// depends on sste_pkg for the item type
module sste_fifo #(
  parameter int Depth = sste_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sste_pkg::seg_item_t push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output sste_pkg::seg_item_t pop_item_o,
  output logic                empty_o
);
  import sste_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  seg_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // occupancy update
  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> design/sste_back.sv
// output stage: pops queued results, applies inversion, drives the
// segment channel from a register; depends on sste_pkg and sste_if
module sste_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                invert_i,
  input  logic                empty_i,
  input  sste_pkg::seg_item_t pop_item_i,
  output logic                pop_o,
  sste_seg_if.source          seg_o
);
  import sste_pkg::*;

  logic             valid_q;
  logic [SEG_W-1:0] segments_q;
  logic             last_q;

  // refill the output register when it is free or being drained
  assign pop_o = !empty_i && (!valid_q || seg_o.ready);

  assign seg_o.valid    = valid_q;
  assign seg_o.segments = segments_q;
  assign seg_o.last     = last_q;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || seg_o.ready) begin
      valid_q <= !empty_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      segments_q <= pop_item_i.pattern ^ (invert_i ? INVERT_MASK : '0);
      last_q     <= pop_item_i.last;
    end
  end

endmodule

>>> design/seven_segment_text_encoder_unit.sv
// Seven-segment text encoder: one character request per clock cycle is
// taken while the result queue has room, and a character that releases a
// pattern offers it on the segment channel through the queue entry, written
// at the accepting edge, and then the output register, loaded once it is free
// or being drained. Each pattern is held one deep and is released only
// when a later character is held in its place or the string ends. With
// the queue at depth two or more the input never stalls while the output
// sink keeps ready high. Configuration is taken one write per cycle; there
// is no clearing pass after reset.
// depends on sste_pkg, sste_if, sste_front, sste_fifo, sste_back
module seven_segment_text_encoder_unit #(
  parameter int QueueDepth = sste_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sste_char_if.sink                  char_i,
  sste_seg_if.source                 seg_o,
  input  logic                       cfg_we_i,
  input  sste_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [sste_pkg::CFG_W-1:0] cfg_data_i
);
  import sste_pkg::*;

  logic               invert_q;
  logic [COUNT_W-1:0] max_chars_q;
  logic               push, full, pop, empty;
  seg_item_t          push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b0;
      max_chars_q <= MAX_CHARS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INVERT:    invert_q    <= cfg_data_i[0];
        CFG_MAX_CHARS: max_chars_q <= cfg_data_i[COUNT_W-1:0];
      endcase
    end
  end

  // character classifier
  sste_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .max_chars_i (max_chars_q),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // result queue
  sste_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  // output stage
  sste_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .invert_i   (invert_q),
    .empty_i    (empty),
    .pop_item_i (pop_item),
    .pop_o      (pop),
    .seg_o      (seg_o)
  );

endmodule

>>> design/sste_checker.sv
// port-level checks for the seven-segment text encoder, bound to the top
// depends on sste_pkg for widths and on the top-level port names
module sste_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       char_ready_i,
  input logic                       seg_valid_i,
  input logic                       seg_ready_i,
  input logic [sste_pkg::SEG_W-1:0] seg_segments_i,
  input logic                       seg_last_i
);

  // no result is offered while reset is applied
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !seg_valid_i)
    else $error("segment request valid during reset");

  // a stalled result request keeps its payload
  a_seg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && !seg_ready_i |=>
      seg_valid_i && $stable(seg_segments_i) && $stable(seg_last_i))
    else $error("segment request changed while stalled");

  // a draining sink frees the queue for the next character
  a_ready_recovers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(seg_ready_i) |-> char_ready_i)
    else $error("character request stalled while output drains");

endmodule

bind seven_segment_text_encoder_unit sste_checker u_sste_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .char_ready_i   (char_i.ready),
  .seg_valid_i    (seg_o.valid),
  .seg_ready_i    (seg_o.ready),
  .seg_segments_i (seg_o.segments),
  .seg_last_i     (seg_o.last)
);

>>> test/tb_seven_segment_text_encoder_unit.sv
// testbench for seven_segment_text_encoder_unit: streams text, predicts every segment pattern
// depends on sste_pkg, sste_if and the encoder RTL
`timescale 1ns / 1ps

module tb_seven_segment_text_encoder_unit;
  import sste_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 90;
  localparam int REPORT_LINES   = 20;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic             last;
  } seg_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_INVERT;
  logic [CFG_W-1:0] cfg_data_i = '0;

  sste_char_if char_if ();
  sste_seg_if  seg_if ();

  seven_segment_text_encoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (char_if),
    .seg_o      (seg_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // text bytes waiting to be sent, and patterns the encoder still owes
  logic [CHAR_W-1:0] pending_chars[$];
  seg_result_t       expected_patterns[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int idle_cycles    = 0;
  int chars_queued   = 0;

  // predictor state
  logic              cfg_invert    = 1'b0;
  logic [COUNT_W-1:0] cfg_max_chars = MAX_CHARS_RESET;
  logic              held_valid    = 1'b0;
  logic [SEG_W-1:0]  held_pattern  = '0;
  logic              held_dot      = 1'b0;
  logic [COUNT_W-1:0] string_count = '0;
  logic              limit_hit     = 1'b0;

  // common-cathode glyph of one text byte
  function automatic logic [SEG_W-1:0] seven_seg_glyph(input logic [CHAR_W-1:0] c);
    case (c)
      "0":      return 8'h3F;
      "1":      return 8'h06;
      "2":      return 8'h5B;
      "3":      return 8'h4F;
      "4":      return 8'h66;
      "5":      return 8'h6D;
      "6":      return 8'h7D;
      "7":      return 8'h07;
      "8":      return 8'h7F;
      "9":      return 8'h6F;
      " ":      return 8'h00;
      "-":      return 8'h40;
      "_":      return 8'h08;
      "C":      return 8'h39;
      "c":      return 8'h58;
      "N":      return 8'h37;
      "n":      return 8'h54;
      "U":      return 8'h3E;
      "u":      return 8'h1C;
      "H":      return 8'h76;
      "h":      return 8'h74;
      "O":      return 8'h3F;
      "o":      return 8'h5C;
      "A", "a": return 8'h77;
      "B", "b": return 8'h7C;
      "D", "d": return 8'h5E;
      "E", "e": return 8'h79;
      "F", "f": return 8'h71;
      "P", "p": return 8'h73;
      "Y", "y": return 8'h6E;
      "L", "l": return 8'h38;
      "T", "t": return 8'h78;
      "Q", "q": return 8'h67;
      "S", "s": return 8'h6D;
      "R", "r": return 8'h50;
      "J", "j": return 8'h0E;
      default:  return UNMAPPED;
    endcase
  endfunction

  function automatic void release_pattern(input logic [SEG_W-1:0] pattern, input logic last);
    seg_result_t r;
    r.segments = pattern ^ (cfg_invert ? INVERT_MASK : '0);
    r.last     = last;
    expected_patterns.push_back(r);
  endfunction

  // advance the predictor by one accepted character
  function automatic void encode_character(input logic [CHAR_W-1:0] c);
    if (c == CHAR_END) begin
      if (held_valid) release_pattern(held_pattern, 1'b1);
      held_valid   = 1'b0;
      held_pattern = '0;
      held_dot     = 1'b0;
      string_count = '0;
      limit_hit    = 1'b0;
      return;
    end
    if (limit_hit) return;
    // dot merges into the held character
    if (c == CHAR_DOT && held_valid && !held_dot) begin
      held_pattern = held_pattern | DP_MASK;
      held_dot     = 1'b1;
      return;
    end
    if (string_count >= cfg_max_chars) begin
      limit_hit = 1'b1;
      return;
    end
    if (held_valid) release_pattern(held_pattern, 1'b0);
    held_valid   = 1'b1;
    held_pattern = seven_seg_glyph(c);
    held_dot     = 1'b0;
    string_count = string_count + 1'b1;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < REPORT_LINES) $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // request driver: holds a request until it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (char_if.valid && char_if.ready) encode_character(char_if.character);
      if (!char_if.valid || char_if.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_if.valid     <= 1'b1;
          char_if.character <= pending_chars.pop_front();
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin
    seg_result_t want;
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      if (expected_patterns.size() == 0) begin
        report_error($sformatf("unexpected pattern %h last %b", seg_if.segments, seg_if.last));
      end else begin
        want = expected_patterns.pop_front();
        if (seg_if.segments !== want.segments)
          report_error($sformatf("segments %h, expected %h", seg_if.segments, want.segments));
        if (seg_if.last !== want.last)
          report_error($sformatf("last %b, expected %b", seg_if.last, want.last));
      end
    end
    seg_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (seg_if.valid && seg_if.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_INVERT:    cfg_invert    = value[0];
      CFG_MAX_CHARS: cfg_max_chars = value[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every request is taken and every pattern has come back
  task automatic drain;
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || char_if.valid || expected_patterns.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
    chars_queued += s.len();
  endtask

  task automatic queue_char(input logic [CHAR_W-1:0] c);
    pending_chars.push_back(c);
    chars_queued++;
  endtask

  // one string of mostly mapped characters and dots, sometimes left open
  task automatic queue_random_string(input int max_len);
    string mapped;
    int len;
    int pick;
    mapped = "0123456789AaBbCcDdEeFfNnUuHhOoPpYyLlTtQqSsRrJj -_";
    len = $urandom_range(max_len, 0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) queue_char(mapped[$urandom_range(mapped.len() - 1, 0)]);
      else if (pick < 80) queue_char(CHAR_DOT);
      else queue_char(CHAR_W'($urandom_range(255, 1)));
    end
    if ($urandom_range(99) >= 10) queue_char(CHAR_END);
  endtask

  task automatic set_pace(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  // stimulus sequence
  initial begin
    logic             phase_invert[8];
    logic [CFG_W-1:0] phase_width[8];
    int phase_end;
    int max_len;

    phase_invert = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_width  = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd8, 8'd255, 8'd5, 8'd16};

    char_if.valid     = 1'b0;
    char_if.character = '0;
    seg_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty string, leading and double dots, control and high codes, limit at reset width
    set_pace(0);
    queue_char(CHAR_END);
    queue_text("...A.");
    queue_char(8'hFF);
    queue_char(8'h01);
    queue_char(8'h20);
    queue_char(8'h7F);
    queue_char(8'h80);
    queue_char(8'h1F);
    queue_char(CHAR_END);
    drain();

    // dot right at the limit, then dots dropped after the limit
    write_register(CFG_MAX_CHARS, 8'd2);
    queue_text("h.q.x");
    queue_char(CHAR_END);
    queue_text("abc.");
    queue_char(CHAR_END);
    drain();

    // zero width with inverted output
    write_register(CFG_INVERT, 8'd1);
    write_register(CFG_MAX_CHARS, 8'd0);
    queue_text("5");
    queue_char(CHAR_END);
    drain();

    // random phases over settings and pacing; strings may straddle phases
    for (int p = 0; p < 8; p++) begin
      write_register(CFG_INVERT, {7'd0, phase_invert[p]});
      write_register(CFG_MAX_CHARS, phase_width[p]);
      set_pace(p % 4);
      phase_end = chars_queued + PHASE_ITEMS;
      if (p == 0) begin
        // one string of 258 eights and dots at the widest display width
        for (int i = 0; i < 258; i++) queue_char($urandom_range(0, 1) ? "8" : CHAR_DOT);
        queue_char(CHAR_END);
      end
      max_len = (phase_width[p] + 3 > 24) ? 24 : phase_width[p] + 3;
      while (chars_queued < phase_end) begin
        if ($urandom_range(99) < 5) queue_char(CHAR_W'($urandom_range(255, 0)));
        else queue_random_string(max_len);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sste_pkg.sv
design/sste_if.sv
design/sste_front.sv
design/sste_fifo.sv
design/sste_back.sv
design/seven_segment_text_encoder_unit.sv
design/sste_checker.sv
test/tb_seven_segment_text_encoder_unit.sv
